>>> hdl/lpt_pkg.sv
// shared codes, widths and the request control struct for the lru page table
package lpt_pkg;

  // fixed field widths
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // parameter defaults
  localparam int MAX_SLOTS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int AGE_WIDTH_DEF  = 16;

  // register map
  localparam logic [APB_AW-1:0] ADDR_ENTRIES_IN_USE = 3'd0;
  localparam logic [CFG_W-1:0]  ENTRIES_RESET       = 5'd16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PLACE_FREE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PLACE_AT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIND_LRU   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SWAP_IN    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd6;
  localparam logic [REQ_W-1:0] REQ_READ_TIMER = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  // control part of a request as it walks down the cell chain
  typedef struct packed {
    logic                vld;
    logic [REQ_W-1:0]    req;
    logic                in_range;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic                any;
  } ctrl_t;

endpackage

>>> hdl/lru_page_table.sv
// top level of the lru page table: config port, cell chain and output register
//
// channel  direction  handshake                 payload
// in       input      in_valid / in_ready       req_type, slot_index, entry_data
// out      output     out_valid / out_ready     status, result_index, result_data,
//                                               result_timer, any_valid
// cfg      input      psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// a request walks the row of MAX_SLOTS cells, one cell per cycle while the chain
// advances, and then into the output register; the chain holds one request
// per cell, so one transfer per cycle is taken while the output keeps draining
// reset clears every valid mark and timer at once and sets entries_in_use to 16
// a stalled output holds its result; the chain still shifts while its last cell
// is empty, and only stops when a result there has nowhere to go
module lru_page_table #(
  parameter int MAX_SLOTS  = lpt_pkg::MAX_SLOTS_DEF,
  parameter int DATA_WIDTH = lpt_pkg::DATA_WIDTH_DEF,
  parameter int AGE_WIDTH  = lpt_pkg::AGE_WIDTH_DEF,
  localparam int IDX_W     = $clog2(MAX_SLOTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lpt_pkg::REQ_W-1:0]    req_type,
  input  logic [IDX_W-1:0]             slot_index,
  input  logic [DATA_WIDTH-1:0]        entry_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lpt_pkg::STATUS_W-1:0] status,
  output logic [IDX_W-1:0]             result_index,
  output logic [DATA_WIDTH-1:0]        result_data,
  output logic [AGE_WIDTH-1:0]         result_timer,
  output logic                         any_valid,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpt_pkg::APB_AW-1:0]   paddr,
  input  logic [lpt_pkg::APB_DW-1:0]   pwdata,
  output logic [lpt_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  // compare width that holds both the slot count and the register value
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > lpt_pkg::CFG_W) ? CNT_W : lpt_pkg::CFG_W;

  logic [lpt_pkg::CFG_W-1:0] entries_in_use;
  logic [CMP_W-1:0]          n_used;
  logic                      adv;

  // chain links: index 0 is the entry, index MAX_SLOTS the last cell's register
  lpt_pkg::ctrl_t        ctl   [0:MAX_SLOTS];
  logic [IDX_W-1:0]      idx   [0:MAX_SLOTS];
  logic [DATA_WIDTH-1:0] wdata [0:MAX_SLOTS];
  logic [DATA_WIDTH-1:0] rdata [0:MAX_SLOTS];
  logic [AGE_WIDTH-1:0]  best  [0:MAX_SLOTS];
  logic [AGE_WIDTH-1:0]  timer [0:MAX_SLOTS];
  logic [IDX_W-1:0]      rindex[0:MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  in_use;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= lpt_pkg::ENTRIES_RESET;
    end else if (psel && penable && pwrite && (paddr == lpt_pkg::ADDR_ENTRIES_IN_USE)) begin
      entries_in_use <= pwdata[lpt_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lpt_pkg::ADDR_ENTRIES_IN_USE) begin
      prdata = {{(lpt_pkg::APB_DW - lpt_pkg::CFG_W){1'b0}}, entries_in_use};
    end
  end

  // a count beyond the table acts as the full table
  assign n_used = (CMP_W'(entries_in_use) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                                : CMP_W'(entries_in_use);

  // ---------------------------------------------------------------- flow
  // the chain moves when its last cell is empty or the output register can take it
  assign adv      = !ctl[MAX_SLOTS].vld || !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------------------------------------------------------- entry
  // the starting status is what the request reports if no cell changes it
  always_comb begin
    ctl[0].vld      = in_valid;
    ctl[0].req      = req_type;
    ctl[0].in_range = (CMP_W'(slot_index) < n_used);
    ctl[0].hit      = 1'b0;
    ctl[0].any      = 1'b0;
    case (req_type)
      lpt_pkg::REQ_PLACE_FREE: ctl[0].status = lpt_pkg::ST_FULL;
      lpt_pkg::REQ_FIND_LRU:   ctl[0].status = lpt_pkg::ST_EMPTY;
      lpt_pkg::REQ_TICK:       ctl[0].status = lpt_pkg::ST_OK;
      default: begin
        ctl[0].status = ctl[0].in_range ? lpt_pkg::ST_OK : lpt_pkg::ST_RANGE;
      end
    endcase
  end

  assign idx[0]    = slot_index;
  assign wdata[0]  = entry_data;
  assign rdata[0]  = '0;
  assign best[0]   = '0;
  assign timer[0]  = '0;
  assign rindex[0] = '0;

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    assign in_use[i] = (CMP_W'(i) < n_used);

    lpt_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .AGE_WIDTH  (AGE_WIDTH),
      .IDX_W      (IDX_W),
      .CELL_ID    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .in_use     (in_use[i]),
      .ctl_in     (ctl[i]),
      .idx_in     (idx[i]),
      .wdata_in   (wdata[i]),
      .rdata_in   (rdata[i]),
      .best_in    (best[i]),
      .timer_in   (timer[i]),
      .rindex_in  (rindex[i]),
      .ctl_out    (ctl[i+1]),
      .idx_out    (idx[i+1]),
      .wdata_out  (wdata[i+1]),
      .rdata_out  (rdata[i+1]),
      .best_out   (best[i+1]),
      .timer_out  (timer[i+1]),
      .rindex_out (rindex[i+1])
    );
  end

  // ---------------------------------------------------------------- output
  // parts the chain from the consumer so a bubble still lets the chain shift
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && ctl[MAX_SLOTS].vld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl[MAX_SLOTS].vld) begin
      status       <= ctl[MAX_SLOTS].status;
      any_valid    <= ctl[MAX_SLOTS].any;
      result_index <= rindex[MAX_SLOTS];
      result_data  <= rdata[MAX_SLOTS];
      result_timer <= timer[MAX_SLOTS];
    end
  end

`ifndef SYNTH
  // input side only stops while a result in the last cell cannot move on
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && ctl[MAX_SLOTS].vld))
    else $error("input stalled without a blocked result");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= lpt_pkg::ST_RANGE))
    else $error("status code out of range");

  a_index_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_index != '0)) |-> (status == lpt_pkg::ST_OK))
    else $error("slot index reported with a failing status");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((result_data != '0) || (result_timer != '0)))
      |-> (status == lpt_pkg::ST_OK))
    else $error("data or timer reported with a failing status");
`endif

endmodule

>>> hdl/lpt_cell.sv
// one slot of the table, acting on the request that passes through it
module lpt_cell #(
  parameter int DATA_WIDTH = lpt_pkg::DATA_WIDTH_DEF,
  parameter int AGE_WIDTH  = lpt_pkg::AGE_WIDTH_DEF,
  parameter int IDX_W      = 4,
  parameter int CELL_ID    = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_use,
  input  lpt_pkg::ctrl_t        ctl_in,
  input  logic [IDX_W-1:0]      idx_in,
  input  logic [DATA_WIDTH-1:0] wdata_in,
  input  logic [DATA_WIDTH-1:0] rdata_in,
  input  logic [AGE_WIDTH-1:0]  best_in,
  input  logic [AGE_WIDTH-1:0]  timer_in,
  input  logic [IDX_W-1:0]      rindex_in,
  output lpt_pkg::ctrl_t        ctl_out,
  output logic [IDX_W-1:0]      idx_out,
  output logic [DATA_WIDTH-1:0] wdata_out,
  output logic [DATA_WIDTH-1:0] rdata_out,
  output logic [AGE_WIDTH-1:0]  best_out,
  output logic [AGE_WIDTH-1:0]  timer_out,
  output logic [IDX_W-1:0]      rindex_out
);

  localparam logic [IDX_W-1:0]     MY_IDX  = IDX_W'(CELL_ID);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  logic                  valid, valid_next;
  logic [DATA_WIDTH-1:0] data, data_next;
  logic [AGE_WIDTH-1:0]  age, age_next;
  lpt_pkg::ctrl_t        ctl_next;
  logic [DATA_WIDTH-1:0] rdata_next;
  logic [AGE_WIDTH-1:0]  best_next, timer_next;
  logic [IDX_W-1:0]      rindex_next;
  logic                  fill, me;

  always_comb begin
    valid_next  = valid;
    data_next   = data;
    age_next    = age;
    ctl_next    = ctl_in;
    rdata_next  = rdata_in;
    best_next   = best_in;
    timer_next  = timer_in;
    rindex_next = rindex_in;
    fill        = 1'b0;
    me          = in_use && ctl_in.in_range && (idx_in == MY_IDX);
    if (ctl_in.vld) begin
      case (ctl_in.req)
        lpt_pkg::REQ_PLACE_FREE: begin
          if (in_use && !valid && !ctl_in.hit) begin
            fill            = 1'b1;
            ctl_next.hit    = 1'b1;
            ctl_next.status = lpt_pkg::ST_OK;
            rindex_next     = MY_IDX;
          end
        end
        lpt_pkg::REQ_PLACE_AT: begin
          if (me) begin
            if (valid) begin
              ctl_next.status = lpt_pkg::ST_OCCUPIED;
            end else begin
              fill        = 1'b1;
              rindex_next = MY_IDX;
            end
          end
        end
        lpt_pkg::REQ_LOOKUP: begin
          if (me) begin
            if (valid) begin
              age_next   = '0;
              rdata_next = data;
            end else begin
              ctl_next.status = lpt_pkg::ST_EMPTY;
            end
          end
        end
        lpt_pkg::REQ_FIND_LRU: begin
          // strict compare keeps the lowest index on ties
          if (in_use && valid && (!ctl_in.hit || age > best_in)) begin
            ctl_next.hit    = 1'b1;
            ctl_next.status = lpt_pkg::ST_OK;
            best_next       = age;
            rindex_next     = MY_IDX;
          end
        end
        lpt_pkg::REQ_SWAP_IN: begin
          if (me) begin
            if (valid) begin
              rdata_next = data;
            end else begin
              ctl_next.status = lpt_pkg::ST_EMPTY;
            end
            fill = 1'b1;
          end
        end
        lpt_pkg::REQ_REMOVE: begin
          if (me) begin
            if (valid) begin
              valid_next = 1'b0;
              age_next   = '0;
            end else begin
              ctl_next.status = lpt_pkg::ST_EMPTY;
            end
          end
        end
        lpt_pkg::REQ_TICK: begin
          if (in_use && valid && (age != AGE_MAX)) begin
            age_next = age + 1'b1;
          end
        end
        lpt_pkg::REQ_READ_TIMER: begin
          if (me) begin
            if (valid) begin
              timer_next = age;
            end else begin
              ctl_next.status = lpt_pkg::ST_EMPTY;
            end
          end
        end
        default: begin
          ctl_next = ctl_in;
        end
      endcase
    end
    if (fill) begin
      valid_next = 1'b1;
      data_next  = wdata_in;
      age_next   = '0;
    end
    ctl_next.any = ctl_in.any | (in_use & valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      age     <= '0;
      ctl_out <= '0;
    end else if (adv) begin
      valid   <= valid_next;
      age     <= age_next;
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data       <= data_next;
      idx_out    <= idx_in;
      wdata_out  <= wdata_in;
      rdata_out  <= rdata_next;
      best_out   <= best_next;
      timer_out  <= timer_next;
      rindex_out <= rindex_next;
    end
  end

endmodule

>>> sim/tb.sv
// testbench for the lru page table: random and directed requests checked against a slot model
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS          = lpt_pkg::MAX_SLOTS_DEF;
  localparam int DW             = lpt_pkg::DATA_WIDTH_DEF;
  localparam int AW             = lpt_pkg::AGE_WIDTH_DEF;
  localparam int IDX_W          = $clog2(SLOTS);
  localparam int REQ_W          = lpt_pkg::REQ_W;
  localparam int STATUS_W       = lpt_pkg::STATUS_W;
  localparam int CFG_W          = lpt_pkg::CFG_W;
  localparam int APB_AW         = lpt_pkg::APB_AW;
  localparam int APB_DW         = lpt_pkg::APB_DW;
  // cycles with no transfer on either channel before the run is called hung
  localparam int WATCHDOG_LIMIT = 2000;
  // settle time after the last result: the cell chain and output register are SLOTS + 1 deep
  localparam int DRAIN_CYCLES   = 2 * (SLOTS + 1) + 6;
  localparam int AGE_TICKS      = 20;

  // one result transfer as the table reports it
  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [IDX_W-1:0]    idx;
    logic [DW-1:0]       data;
    logic [AW-1:0]       timer;
    logic                any;
  } table_result_t;

  // slot table model plus the queue of results it predicts
  class slot_table_checker;
    bit               valid_mark [SLOTS];
    logic [DW-1:0]    data_word  [SLOTS];
    logic [AW-1:0]    age        [SLOTS];
    logic [CFG_W-1:0] entries;
    table_result_t    pending_results [$];
    int               fails;
    int               checked;
    int               status_count [5];

    function new();
      entries = lpt_pkg::ENTRIES_RESET;
      fails   = 0;
      checked = 0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_mark[i] = 1'b0;
        data_word[i]  = '0;
        age[i]        = '0;
      end
      foreach (status_count[s]) status_count[s] = 0;
    endfunction

    function int slots_used();
      return (entries > SLOTS) ? SLOTS : int'(entries);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void fill(int i, logic [DW-1:0] d);
      valid_mark[i] = 1'b1;
      data_word[i]  = d;
      age[i]        = '0;
    endfunction

    function void accept_request(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                                 logic [DW-1:0] d);
      table_result_t r;
      int            n;
      bit            found;
      logic [AW-1:0] best;
      n     = slots_used();
      r     = '0;
      found = 1'b0;
      best  = '0;
      r.st  = lpt_pkg::ST_OK;
      case (req)
        lpt_pkg::REQ_PLACE_FREE: begin
          r.st = lpt_pkg::ST_FULL;
          for (int i = 0; i < n; i++) begin
            if (!found && !valid_mark[i]) begin
              fill(i, d);
              found = 1'b1;
              r.st  = lpt_pkg::ST_OK;
              r.idx = IDX_W'(i);
            end
          end
        end
        lpt_pkg::REQ_FIND_LRU: begin
          for (int i = 0; i < n; i++) begin
            if (valid_mark[i] && (!found || age[i] > best)) begin
              found = 1'b1;
              best  = age[i];
              r.idx = IDX_W'(i);
            end
          end
          r.st = found ? lpt_pkg::ST_OK : lpt_pkg::ST_EMPTY;
        end
        lpt_pkg::REQ_TICK: begin
          for (int i = 0; i < n; i++)
            if (valid_mark[i] && age[i] != '1) age[i] = age[i] + 1'b1;
        end
        default: begin
          if (int'(idx) >= n) begin
            r.st = lpt_pkg::ST_RANGE;
          end else begin
            case (req)
              lpt_pkg::REQ_PLACE_AT: begin
                if (valid_mark[idx]) begin
                  r.st = lpt_pkg::ST_OCCUPIED;
                end else begin
                  fill(int'(idx), d);
                  r.idx = idx;
                end
              end
              lpt_pkg::REQ_LOOKUP: begin
                if (valid_mark[idx]) begin
                  age[idx] = '0;
                  r.data   = data_word[idx];
                end else begin
                  r.st = lpt_pkg::ST_EMPTY;
                end
              end
              lpt_pkg::REQ_SWAP_IN: begin
                if (valid_mark[idx]) r.data = data_word[idx];
                else r.st = lpt_pkg::ST_EMPTY;
                fill(int'(idx), d);
              end
              lpt_pkg::REQ_REMOVE: begin
                if (valid_mark[idx]) begin
                  valid_mark[idx] = 1'b0;
                  age[idx]        = '0;
                end else begin
                  r.st = lpt_pkg::ST_EMPTY;
                end
              end
              default: begin
                if (valid_mark[idx]) r.timer = age[idx];
                else r.st = lpt_pkg::ST_EMPTY;
              end
            endcase
          end
        end
      endcase
      for (int i = 0; i < n; i++)
        if (valid_mark[i]) r.any = 1'b1;
      status_count[r.st]++;
      pending_results = {pending_results, r};
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d index %0d data %h timer %0d",
                 $time, got.st, got.idx, got.data, got.timer);
        fails++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      compare("status",       64'(want.st),    64'(got.st));
      compare("result_index", 64'(want.idx),   64'(got.idx));
      compare("result_data",  64'(want.data),  64'(got.data));
      compare("result_timer", 64'(want.timer), 64'(got.timer));
      compare("any_valid",    64'(want.any),   64'(got.any));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type;
  logic [IDX_W-1:0]    slot_index;
  logic [DW-1:0]       entry_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    result_index;
  logic [DW-1:0]       result_data;
  logic [AW-1:0]       result_timer;
  logic                any_valid;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  slot_table_checker slot_chk = new();

  // no_idle turns off the random gaps on both channels for one stretch
  bit no_idle = 1'b0;
  int n_requests = 0;
  int n_sizes = 1;
  int quiet_cycles = 0;

  lru_page_table #(
    .MAX_SLOTS  (SLOTS),
    .DATA_WIDTH (DW),
    .AGE_WIDTH  (AW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .slot_index   (slot_index),
    .entry_data   (entry_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_index (result_index),
    .result_data  (result_data),
    .result_timer (result_timer),
    .any_valid    (any_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: stall at random on the falling edge, unless in a no-idle stretch
  always @(negedge clk) begin
    out_ready = no_idle || ($urandom_range(0, 99) >= 32);
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      slot_chk.check_result(table_result_t'{status, result_index, result_data,
                                            result_timer, any_valid});
  end

  // watchdog: a run that moves nothing for too long is hung
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, slot_chk.pending());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // one request transfer; valid stays up with the same payload until taken
  task automatic push_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                              input logic [DW-1:0] d);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    req_type   = req;
    slot_index = idx;
    entry_data = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    slot_chk.accept_request(req, idx, d);
    n_requests++;
  endtask

  // drop valid, let every predicted result arrive, then let the chain settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (slot_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write of entries_in_use with junk in the unused upper bits, then a read back
  task automatic write_entries(input logic [CFG_W-1:0] v);
    logic [APB_DW-1:0] word;
    word          = $urandom();
    word[CFG_W-1:0] = v;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = lpt_pkg::ADDR_ENTRIES_IN_USE;
    pwdata  = word;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    slot_chk.entries = v;
    n_sizes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(v)) begin
      $display("%0t: entries_in_use read back, expected %h actual %h", $time,
               APB_DW'(v), prdata);
      slot_chk.fails++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // random mix: place_pct percent placements, the rest spread over the other requests;
  // indexes mostly within the slots in use, some anywhere
  task automatic run_mix(input int count, input int place_pct);
    logic [REQ_W-1:0] others [6] = '{lpt_pkg::REQ_LOOKUP, lpt_pkg::REQ_FIND_LRU,
                                     lpt_pkg::REQ_SWAP_IN, lpt_pkg::REQ_REMOVE,
                                     lpt_pkg::REQ_TICK, lpt_pkg::REQ_READ_TIMER};
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    int               n;
    for (int k = 0; k < count; k++) begin
      n = slot_chk.slots_used();
      if ($urandom_range(0, 99) < place_pct)
        req = $urandom_range(0, 1) ? lpt_pkg::REQ_PLACE_FREE : lpt_pkg::REQ_PLACE_AT;
      else
        req = others[$urandom_range(0, 5)];
      if (n > 0 && $urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, n - 1));
      else idx = IDX_W'($urandom_range(0, SLOTS - 1));
      push_request(req, idx, $urandom());
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = lpt_pkg::REQ_TICK;
    slot_index = '0;
    entry_data = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = lpt_pkg::ADDR_ENTRIES_IN_USE;
    pwdata     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty table cases first, then placement, aging, ties and removal
    push_request(lpt_pkg::REQ_FIND_LRU,   4'd0,  '0);
    push_request(lpt_pkg::REQ_TICK,       4'd0,  '0);
    push_request(lpt_pkg::REQ_LOOKUP,     4'd0,  '0);
    push_request(lpt_pkg::REQ_REMOVE,     4'd15, '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd7,  '0);
    // swap into an empty slot still fills it
    push_request(lpt_pkg::REQ_SWAP_IN,    4'd5,  32'hFFFF_FFFF);
    push_request(lpt_pkg::REQ_PLACE_FREE, 4'd9,  32'h0000_0000);
    push_request(lpt_pkg::REQ_PLACE_AT,   4'd5,  32'h1111_1111);
    push_request(lpt_pkg::REQ_PLACE_AT,   4'd15, 32'hA5A5_A5A5);
    push_request(lpt_pkg::REQ_TICK,       4'd0,  '0);
    push_request(lpt_pkg::REQ_TICK,       4'd0,  '0);
    push_request(lpt_pkg::REQ_LOOKUP,     4'd5,  '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd0,  '0);
    // slots 0 and 15 tie on age: lowest index wins
    push_request(lpt_pkg::REQ_FIND_LRU,   4'd0,  '0);
    push_request(lpt_pkg::REQ_SWAP_IN,    4'd0,  32'h1234_5678);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd15, '0);
    push_request(lpt_pkg::REQ_FIND_LRU,   4'd0,  '0);
    push_request(lpt_pkg::REQ_REMOVE,     4'd15, '0);
    push_request(lpt_pkg::REQ_REMOVE,     4'd15, '0);
    push_request(lpt_pkg::REQ_PLACE_FREE, 4'd0,  32'h5A5A_5A5A);
    push_request(lpt_pkg::REQ_LOOKUP,     4'd0,  '0);
    push_request(lpt_pkg::REQ_TICK,       4'd0,  '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd1,  '0);
    wait_idle();

    // random phases across table sizes, including zero and counts past the table
    run_mix(200, 45);
    wait_idle();
    write_entries(5'd1);
    run_mix(120, 30);
    wait_idle();
    write_entries(5'd0);
    run_mix(60, 30);
    wait_idle();
    write_entries(5'd31);
    no_idle = 1'b1;
    run_mix(200, 45);
    wait_idle();
    no_idle = 1'b0;
    write_entries(5'd17);
    run_mix(100, 20);
    wait_idle();
    write_entries(CFG_W'($urandom_range(3, 15)));
    run_mix(150, 40);
    wait_idle();

    // timer aging on a two-slot table
    write_entries(5'd2);
    push_request(lpt_pkg::REQ_REMOVE,   4'd0, '0);
    push_request(lpt_pkg::REQ_REMOVE,   4'd1, '0);
    push_request(lpt_pkg::REQ_PLACE_AT, 4'd1, $urandom());
    for (int k = 0; k < AGE_TICKS; k++) push_request(lpt_pkg::REQ_TICK, 4'd0, '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd1, '0);
    push_request(lpt_pkg::REQ_PLACE_AT,   4'd0, $urandom());
    push_request(lpt_pkg::REQ_FIND_LRU,   4'd0, '0);
    push_request(lpt_pkg::REQ_TICK,       4'd0, '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd1, '0);
    push_request(lpt_pkg::REQ_LOOKUP,     4'd1, '0);
    push_request(lpt_pkg::REQ_READ_TIMER, 4'd1, '0);
    wait_idle();

    write_entries(5'd16);
    run_mix(250, 25);
    wait_idle();

    $display("covered %0d requests over %0d table sizes, %0d results checked",
             n_requests, n_sizes, slot_chk.checked);
    $display("statuses: ok %0d, full %0d, occupied %0d, empty %0d, out of range %0d",
             slot_chk.status_count[0], slot_chk.status_count[1], slot_chk.status_count[2],
             slot_chk.status_count[3], slot_chk.status_count[4]);
    if (slot_chk.fails == 0 && slot_chk.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
